// ===== hw/rtl/ttf_pkg.sv =====
package ttf_pkg;

  // fixed field widths
  localparam int MODE_W    = 1;
  localparam int TIDX_W    = 12;
  localparam int TVAL_W    = 8;
  localparam int OFFSET_W  = 23;
  localparam int WIDTH_W   = 12;
  localparam int HEIGHT_W  = 12;
  localparam int PITCH_W   = 13;
  localparam int STEP_W    = 24;
  localparam int SCALE_W   = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // tile geometry
  localparam int TILE_SIZE   = 64;
  localparam int TILE_BITS   = 6;
  localparam int STORE_DEPTH = TILE_SIZE * TILE_SIZE;

  // parameter defaults
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_PITCH  = 4096;
  localparam int DEF_FRAC_WIDTH = 16;

  // queue depths
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // register reset values
  localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(320);
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(200);
  localparam logic [PITCH_W-1:0]  RST_PITCH  = PITCH_W'(320);
  localparam logic [STEP_W-1:0]   RST_STEP   = STEP_W'(65536);

  typedef enum logic [SCALE_W-1:0] {
    SCALE_UNIT    = 2'd0,
    SCALE_DOUBLE  = 2'd1,
    SCALE_GENERAL = 2'd2
  } scale_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_PITCH  = 3'd2,
    REG_XSTEP  = 3'd3,
    REG_YSTEP  = 3'd4,
    REG_SCALE  = 3'd5
  } reg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [PITCH_W-1:0]  pitch;
    logic [STEP_W-1:0]   x_step;
    logic [STEP_W-1:0]   y_step;
    logic [SCALE_W-1:0]  scale;
  } cfg_t;

  // one beat between front and back
  typedef struct packed {
    logic                is_load;
    logic [TIDX_W-1:0]   addr;
    logic [TVAL_W-1:0]   value;
    logic [OFFSET_W-1:0] offset;
    logic                frame_end;
  } cmd_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [TVAL_W-1:0]   pixel;
    logic                frame_end;
  } res_t;

endpackage

// ===== hw/rtl/ttf_fifo.sv =====
module ttf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/ttf_front.sv =====
module ttf_front #(
  parameter int MAX_WIDTH  = ttf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ttf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_PITCH  = ttf_pkg::DEF_MAX_PITCH,
  parameter int FRAC_WIDTH = ttf_pkg::DEF_FRAC_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ttf_pkg::cfg_t              cfg,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [ttf_pkg::MODE_W-1:0] in_mode,
  input  logic [ttf_pkg::TIDX_W-1:0] in_texel_index,
  input  logic [ttf_pkg::TVAL_W-1:0] in_texel_value,
  output logic                       cmd_push,
  output ttf_pkg::cmd_t              cmd,
  input  logic                       cmd_full
);
  import ttf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int PW = $clog2(MAX_PITCH + 1);
  localparam int AW = TILE_BITS + FRAC_WIDTH;
  localparam int SH = 16 - FRAC_WIDTH;

  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [AW-1:0]       xacc_r, xacc_nxt;
  logic [AW-1:0]       yacc_r, yacc_nxt;
  logic [OFFSET_W-1:0] base_r, base_nxt;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [PW-1:0] p_eff;
  logic [AW-1:0] xs, ys;
  logic          accept, is_step, row_last, frame_last;

  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;
  assign is_step  = (in_mode == MODE_STEP);
  assign cmd_push = accept;

  // zero width or height acts as one, oversize saturates
  always_comb begin
    if (cfg.width == '0) begin
      w_eff = CW'(1);
    end else if (32'(cfg.width) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg.width);
    end
    if (cfg.height == '0) begin
      h_eff = RW'(1);
    end else if (32'(cfg.height) > 32'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg.height);
    end
    if (32'(cfg.pitch) > 32'(MAX_PITCH)) begin
      p_eff = PW'(MAX_PITCH);
    end else begin
      p_eff = PW'(cfg.pitch);
    end
  end

  always_comb begin
    case (cfg.scale)
      SCALE_UNIT: begin
        xs = AW'(1) << FRAC_WIDTH;
        ys = AW'(1) << FRAC_WIDTH;
      end
      SCALE_DOUBLE: begin
        xs = AW'(1) << (FRAC_WIDTH - 1);
        ys = AW'(1) << (FRAC_WIDTH - 1);
      end
      default: begin
        xs = AW'(cfg.x_step >> SH);
        ys = AW'(cfg.y_step >> SH);
      end
    endcase
  end

  assign row_last   = ((CW + 1)'(col_r) + 1'b1) >= (CW + 1)'(w_eff);
  assign frame_last = row_last && (((RW + 1)'(row_r) + 1'b1) >= (RW + 1)'(h_eff));

  always_comb begin
    cmd.is_load   = !is_step;
    cmd.value     = in_texel_value;
    cmd.addr      = is_step ? {yacc_r[AW-1:FRAC_WIDTH], xacc_r[AW-1:FRAC_WIDTH]}
                            : in_texel_index;
    cmd.offset    = OFFSET_W'(base_r + OFFSET_W'(col_r));
    cmd.frame_end = frame_last;
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    xacc_nxt = xacc_r;
    yacc_nxt = yacc_r;
    base_nxt = base_r;
    if (accept && is_step) begin
      if (frame_last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        xacc_nxt = '0;
        yacc_nxt = '0;
        base_nxt = '0;
      end else if (row_last) begin
        col_nxt  = '0;
        xacc_nxt = '0;
        row_nxt  = RW'(row_r + 1'b1);
        yacc_nxt = AW'(yacc_r + ys);
        base_nxt = OFFSET_W'(base_r + OFFSET_W'(p_eff));
      end else begin
        col_nxt  = CW'(col_r + 1'b1);
        xacc_nxt = AW'(xacc_r + xs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      xacc_r <= '0;
      yacc_r <= '0;
      base_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      xacc_r <= xacc_nxt;
      yacc_r <= yacc_nxt;
      base_r <= base_nxt;
    end
  end

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < 32'(MAX_WIDTH))
    else $error("column counter past max width");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_step && frame_last) |=> (col_r == '0 && row_r == '0 && base_r == '0))
    else $error("frame end did not restart raster");

endmodule

// ===== hw/rtl/ttf_back.sv =====
module ttf_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_empty,
  input  ttf_pkg::cmd_t                cmd,
  output logic                         cmd_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [ttf_pkg::OFFSET_W-1:0] out_dest_offset,
  output logic [ttf_pkg::TVAL_W-1:0]   out_pixel,
  output logic                         out_frame_end
);
  import ttf_pkg::*;

  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [TVAL_W-1:0]   tex_mem [STORE_DEPTH];
  logic [TVAL_W-1:0]   rd_data_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                fe_r;
  logic                rd_vld_r, rd_vld_nxt;
  logic [OCW-1:0]      out_cnt;
  logic                out_full;
  logic                room;
  res_t                res_in, res_out;

  // keep a slot for the read in flight
  assign room    = (32'(out_cnt) + 32'(rd_vld_r)) < 32'(OUT_DEPTH);
  assign cmd_pop = !cmd_empty && (cmd.is_load || room);
  assign rd_vld_nxt = cmd_pop && !cmd.is_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_load) begin
      tex_mem[cmd.addr] <= cmd.value;
    end
    if (rd_vld_nxt) begin
      rd_data_r <= tex_mem[cmd.addr];
      offset_r  <= cmd.offset;
      fe_r      <= cmd.frame_end;
    end
  end

  always_comb begin
    res_in.offset    = offset_r;
    res_in.pixel     = rd_data_r;
    res_in.frame_end = fe_r;
  end

  ttf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rd_vld_r),
    .wdata (res_in),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty),
    .count (out_cnt)
  );

  assign out_dest_offset = res_out.offset;
  assign out_pixel       = res_out.pixel;
  assign out_frame_end   = res_out.frame_end;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> !out_full)
    else $error("result queue full with read in flight");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.is_load) |=> !rd_vld_r)
    else $error("load beat produced a result");

endmodule

// ===== hw/rtl/tiled_texture_fill_unit.sv =====
// Channel   Ports                                          Handshake
// ------    ---------------------------------------------  -------------------------
// input     in_mode, in_texel_index, in_texel_value        in_push & !in_full
// result    out_dest_offset, out_pixel, out_frame_end      out_pop & !out_empty
// config    cfg_index, cfg_data                            cfg_we, no wait
//
// One beat per cycle in, one result per cycle out in steady state.
// Step beats are written to the command queue on the accepting edge, read from
// the texture RAM (registered) once popped, then written to the result queue,
// which takes out_empty low. Load beats give no result.
// Reset (rst_n, synchronous) clears raster counters, queues and config to
// defaults; the texture RAM is not cleared.
// in_full follows the command queue; the back end holds step beats only while the
// result queue lacks room, so each side can hold off without blocking the other.
module tiled_texture_fill_unit #(
  parameter int MAX_WIDTH  = ttf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ttf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_PITCH  = ttf_pkg::DEF_MAX_PITCH,
  parameter int FRAC_WIDTH = ttf_pkg::DEF_FRAC_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // config
  input  logic                          cfg_we,
  input  logic [ttf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ttf_pkg::CFG_DAT_W-1:0] cfg_data,
  // input beats
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [ttf_pkg::MODE_W-1:0]    in_mode,
  input  logic [ttf_pkg::TIDX_W-1:0]    in_texel_index,
  input  logic [ttf_pkg::TVAL_W-1:0]    in_texel_value,
  // result beats
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [ttf_pkg::OFFSET_W-1:0]  out_dest_offset,
  output logic [ttf_pkg::TVAL_W-1:0]    out_pixel,
  output logic                          out_frame_end
);
  import ttf_pkg::*;

  localparam int CQW = $clog2(CMD_DEPTH + 1);

  cfg_t cfg_r, cfg_nxt;

  // register file; unknown indexes fall through
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_nxt.width  = cfg_data[WIDTH_W-1:0];
        REG_HEIGHT: cfg_nxt.height = cfg_data[HEIGHT_W-1:0];
        REG_PITCH:  cfg_nxt.pitch  = cfg_data[PITCH_W-1:0];
        REG_XSTEP:  cfg_nxt.x_step = cfg_data[STEP_W-1:0];
        REG_YSTEP:  cfg_nxt.y_step = cfg_data[STEP_W-1:0];
        REG_SCALE:  cfg_nxt.scale  = cfg_data[SCALE_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= RST_WIDTH;
      cfg_r.height <= RST_HEIGHT;
      cfg_r.pitch  <= RST_PITCH;
      cfg_r.x_step <= RST_STEP;
      cfg_r.y_step <= RST_STEP;
      cfg_r.scale  <= SCALE_UNIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: classify beats, walk raster, build commands
  logic           cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t           cmd_in, cmd_out;
  logic [CQW-1:0] cmd_cnt;

  ttf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_PITCH  (MAX_PITCH),
    .FRAC_WIDTH (FRAC_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_texel_index (in_texel_index),
    .in_texel_value (in_texel_value),
    .cmd_push       (cmd_push),
    .cmd            (cmd_in),
    .cmd_full       (cmd_full)
  );

  // decoupling queue, keeps load/step order
  ttf_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty),
    .count (cmd_cnt)
  );

  // back: texture RAM writes and reads, result queue
  ttf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd_out),
    .cmd_pop         (cmd_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_dest_offset (out_dest_offset),
    .out_pixel       (out_pixel),
    .out_frame_end   (out_frame_end)
  );

  a_cmd_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_cnt == '0) == cmd_empty)
    else $error("command queue count and empty disagree");

endmodule

// ===== tb/sv/tiled_texture_fill_unit_tb.sv =====
module tiled_texture_fill_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttf_pkg::*;

  // accumulator: 6 integer bits over the fraction, wraps at the tile size
  localparam int ACC_W = TILE_BITS + DEF_FRAC_WIDTH;
  // indexes and scale code outside the defined set
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [SCALE_W-1:0]   SCALE_SPARE  = 2'd3;
  localparam int PHASES       = 13;
  localparam int PHASE_BEATS  = 100;
  localparam int SETTLE_CYCLES = 8;

  // Tracks the register file, the texture store and the raster position,
  // and holds the destination writes still owed by the block.
  class fill_tracker;
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [PITCH_W-1:0]  pitch;
    logic [STEP_W-1:0]   x_step;
    logic [STEP_W-1:0]   y_step;
    logic [SCALE_W-1:0]  scale;
    logic [TVAL_W-1:0]   texels [STORE_DEPTH];
    bit                  loaded [STORE_DEPTH];
    logic [10:0]         col;
    logic [10:0]         row;
    logic [ACC_W-1:0]    xacc;
    logic [ACC_W-1:0]    yacc;
    logic [OFFSET_W-1:0] row_base;
    res_t                expected_writes[$];
    int                  mismatches;

    function new();
      width      = RST_WIDTH;
      height     = RST_HEIGHT;
      pitch      = RST_PITCH;
      x_step     = RST_STEP;
      y_step     = RST_STEP;
      scale      = SCALE_UNIT;
      col        = '0;
      row        = '0;
      xacc       = '0;
      yacc       = '0;
      row_base   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_WIDTH:  width  = data[WIDTH_W-1:0];
        REG_HEIGHT: height = data[HEIGHT_W-1:0];
        REG_PITCH:  pitch  = data[PITCH_W-1:0];
        REG_XSTEP:  x_step = data[STEP_W-1:0];
        REG_YSTEP:  y_step = data[STEP_W-1:0];
        REG_SCALE:  scale  = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // texel the next step beat will read
    function logic [TIDX_W-1:0] next_texel();
      return {yacc[ACC_W-1 -: TILE_BITS], xacc[ACC_W-1 -: TILE_BITS]};
    endfunction

    function void note_beat(mode_t m, logic [TIDX_W-1:0] idx, logic [TVAL_W-1:0] val);
      logic [WIDTH_W-1:0]  w;
      logic [HEIGHT_W-1:0] h;
      logic [PITCH_W-1:0]  p;
      logic [STEP_W-1:0]   xs;
      logic [STEP_W-1:0]   ys;
      logic                row_last;
      logic                frame_last;
      res_t                r;
      if (m == MODE_LOAD) begin
        texels[idx] = val;
        loaded[idx] = 1'b1;
        return;
      end
      // zero size acts as one, oversize saturates; short pitch stays as is
      w = (width == 0) ? WIDTH_W'(1) :
          (width > DEF_MAX_WIDTH) ? WIDTH_W'(DEF_MAX_WIDTH) : width;
      h = (height == 0) ? HEIGHT_W'(1) :
          (height > DEF_MAX_HEIGHT) ? HEIGHT_W'(DEF_MAX_HEIGHT) : height;
      p = (pitch > DEF_MAX_PITCH) ? PITCH_W'(DEF_MAX_PITCH) : pitch;
      case (scale)
        SCALE_UNIT: begin
          xs = STEP_W'(1) << DEF_FRAC_WIDTH;
          ys = xs;
        end
        SCALE_DOUBLE: begin
          xs = STEP_W'(1) << (DEF_FRAC_WIDTH - 1);
          ys = xs;
        end
        default: begin  // general, spare code too
          xs = x_step >> (16 - DEF_FRAC_WIDTH);
          ys = y_step >> (16 - DEF_FRAC_WIDTH);
        end
      endcase
      row_last   = ({1'b0, col} + 12'd1) >= w;
      frame_last = row_last && (({1'b0, row} + 12'd1) >= h);
      r.offset    = row_base + OFFSET_W'(col);
      r.pixel     = texels[next_texel()];
      r.frame_end = frame_last;
      expected_writes.push_back(r);
      if (frame_last) begin
        col      = '0;
        row      = '0;
        xacc     = '0;
        yacc     = '0;
        row_base = '0;
      end else if (row_last) begin
        col      = '0;
        xacc     = '0;
        row      = row + 11'd1;
        yacc     = yacc + ACC_W'(ys);
        row_base = row_base + OFFSET_W'(p);
      end else begin
        col  = col + 11'd1;
        xacc = xacc + ACC_W'(xs);
      end
    endfunction

    function void check_write(logic [OFFSET_W-1:0] offset, logic [TVAL_W-1:0] pixel,
                              logic frame_end);
      res_t e;
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected dest write: offset %h pixel %h frame_end %b",
                   offset, pixel, frame_end);
        return;
      end
      e = expected_writes.pop_front();
      if (e.offset !== offset || e.pixel !== pixel || e.frame_end !== frame_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("dest write mismatch: offset exp %h got %h, pixel exp %h got %h, %s",
                   e.offset, offset, e.pixel, pixel,
                   $sformatf("frame_end exp %b got %b", e.frame_end, frame_end));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DAT_W-1:0]  cfg_data       = '0;
  logic                  in_push        = 1'b0;
  logic                  in_full;
  logic [MODE_W-1:0]     in_mode        = '0;
  logic [TIDX_W-1:0]     in_texel_index = '0;
  logic [TVAL_W-1:0]     in_texel_value = '0;
  logic                  out_empty;
  logic                  out_pop        = 1'b0;
  logic [OFFSET_W-1:0]   out_dest_offset;
  logic [TVAL_W-1:0]     out_pixel;
  logic                  out_frame_end;

  fill_tracker sb;
  bit          no_idle = 1'b0;  // phase-wide: both sides run back to back
  int          pop_gap = 0;
  int          sent    = 0;     // input beats taken so far, loads included

  tiled_texture_fill_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_mode         (in_mode),
    .in_texel_index  (in_texel_index),
    .in_texel_value  (in_texel_value),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_dest_offset (out_dest_offset),
    .out_pixel       (out_pixel),
    .out_frame_end   (out_frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop; the slowest legal run needs well under a tenth of this
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: every beat is checked as it leaves, then pop drops for a
  // random gap, possibly none, before the next one.
  always @(posedge clk) begin : result_sink
    int gap;
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap <= 0;
    end else if (out_pop && !out_empty) begin
      sb.check_write(out_dest_offset, out_pixel, out_frame_end);
      gap = no_idle ? 0 : $urandom_range(0, 4);
      out_pop <= (gap == 0);
      pop_gap <= gap;
    end else if (pop_gap > 1) begin
      pop_gap <= pop_gap - 1;
    end else begin
      pop_gap <= 0;
      out_pop <= 1'b1;
    end
  end

  // One input beat: optional idle gap, then hold push until the beat is taken.
  // push stays high on return so back-to-back beats leave no hole.
  task automatic push_beat(mode_t m, logic [TIDX_W-1:0] idx, logic [TVAL_W-1:0] val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_mode        <= m;
    in_texel_index <= idx;
    in_texel_value <= val;
    do @(posedge clk); while (in_full);
    sb.note_beat(m, idx, val);
    sent++;
  endtask

  // A step beat never reads an unloaded texel: load it first if needed.
  // Index and value ride along as noise, the block ignores them.
  task automatic step_beat();
    logic [TIDX_W-1:0] t;
    t = sb.next_texel();
    if (!sb.loaded[t])
      push_beat(MODE_LOAD, t, TVAL_W'($urandom));
    push_beat(MODE_STEP, TIDX_W'($urandom), TVAL_W'($urandom));
  endtask

  // Sender holds off until every owed write is out; loads give no result,
  // so extra cycles let the tail of the pipe empty before a register write.
  task automatic drain(int extra);
    in_push <= 1'b0;
    do @(posedge clk); while (sb.expected_writes.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Register write; bits above the register width carry random noise.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    logic [CFG_DAT_W-1:0] mask;
    logic [CFG_DAT_W-1:0] data;
    case (idx)
      REG_WIDTH:  mask = CFG_DAT_W'((1 << WIDTH_W) - 1);
      REG_HEIGHT: mask = CFG_DAT_W'((1 << HEIGHT_W) - 1);
      REG_PITCH:  mask = CFG_DAT_W'((1 << PITCH_W) - 1);
      REG_XSTEP:  mask = '1;
      REG_YSTEP:  mask = '1;
      REG_SCALE:  mask = CFG_DAT_W'((1 << SCALE_W) - 1);
      default:    mask = '0;
    endcase
    data = (CFG_DAT_W'($urandom) & ~mask) | (val & mask);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(int w, int h, int p, logic [SCALE_W-1:0] s, int xs, int ys);
    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DAT_W'($urandom));
    write_reg(REG_WIDTH, CFG_DAT_W'(w));
    write_reg(REG_HEIGHT, CFG_DAT_W'(h));
    write_reg(REG_PITCH, CFG_DAT_W'(p));
    write_reg(REG_XSTEP, CFG_DAT_W'(xs));
    write_reg(REG_YSTEP, CFG_DAT_W'(ys));
    write_reg(REG_SCALE, CFG_DAT_W'(s));
  endtask

  // either a small step (a few texels) or any 24-bit value
  function automatic int rand_step();
    return $urandom_range(0, 1) ? $urandom_range(0, 24'h3FFFF) : ($urandom & 24'hFFFFFF);
  endfunction

  // Register settings per phase flavor; saturation and zero extremes show up
  // in the tall, wide and fixed-coordinate flavors.
  task automatic configure(int kind);
    int w;
    int h;
    int p;
    case (kind)
      0: begin  // small frames, any scale, pitch sometimes under width
        w = $urandom_range(1, 70);
        h = $urandom_range(1, 5);
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, w) : w + $urandom_range(0, 30);
        load_regs(w, h, p, SCALE_W'($urandom_range(0, 3)), rand_step(), rand_step());
      end
      1: begin  // one pixel per row, rows stride by up to the saturated pitch
        w = $urandom_range(0, 1);
        h = $urandom_range(0, 1) ? 4095 : $urandom_range(2, 4095);
        p = $urandom_range(0, 1) ? 8191 : $urandom_range(0, 8191);
        load_regs(w, h, p, SCALE_W'($urandom_range(0, 3)), rand_step(), rand_step());
      end
      2: begin  // width at or past the max, very few rows
        w = $urandom_range(0, 1) ? 4095 : $urandom_range(2048, 4095);
        h = $urandom_range(0, 2);
        p = $urandom_range(0, 1) ? 8191 : $urandom_range(0, 8191);
        load_regs(w, h, p, SCALE_W'($urandom_range(0, 3)), rand_step(), rand_step());
      end
      3: begin  // classic screen size, fixed scales
        load_regs(320, 200, $urandom_range(320, 400),
                  $urandom_range(0, 1) ? SCALE_UNIT : SCALE_DOUBLE, rand_step(), rand_step());
      end
      default: begin  // general steps at zero or all ones
        w = $urandom_range(0, 90);
        h = $urandom_range(0, 4);
        p = $urandom_range(0, 200);
        load_regs(w, h, p, $urandom_range(0, 1) ? SCALE_GENERAL : SCALE_SPARE,
                  $urandom_range(0, 1) ? 0 : 24'hFFFFFF, $urandom_range(0, 1) ? 0 : 24'hFFFFFF);
      end
    endcase
  endtask

  initial begin
    int kind;
    int pause_at;
    int phase_start;
    bit paused;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // reset registers: unscaled 320x200; texel corners and alternating bits
    push_beat(MODE_LOAD, 12'h000, 8'h00);
    push_beat(MODE_LOAD, 12'hFFF, 8'hFF);
    push_beat(MODE_LOAD, 12'hAAA, 8'h55);
    push_beat(MODE_LOAD, 12'h555, 8'hAA);
    repeat (3) step_beat();
    drain(SETTLE_CYCLES);

    // 3x2 frame, 1.5 x step, y step close to a full tile: frame end and restart
    load_regs(3, 2, 5, SCALE_GENERAL, 24'h018000, 24'h3F8000);
    repeat (7) step_beat();
    drain(SETTLE_CYCLES);

    // zero width/height/pitch, spare scale code, zero and max steps
    load_regs(0, 0, 0, SCALE_SPARE, 0, 24'hFFFFFF);
    repeat (3) step_beat();
    drain(SETTLE_CYCLES);

    // --- random phases; frame position carries over each register change ---
    // phase length counts every beat sent, texel loads ahead of steps too
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = (ph < 5) ? ph : $urandom_range(0, 4);
      configure(kind);
      no_idle     = ($urandom_range(0, 3) == 0);
      pause_at    = (ph % 3 == 0) ? $urandom_range(20, 80) : -1;
      phase_start = sent;
      paused      = 1'b0;
      while (sent - phase_start < PHASE_BEATS) begin
        if (!paused && pause_at >= 0 && sent - phase_start >= pause_at) begin
          drain(0);
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 8)
          step_beat();
        else
          push_beat(MODE_LOAD, TIDX_W'($urandom), TVAL_W'($urandom));
      end
      drain(SETTLE_CYCLES);
    end

    no_idle = 1'b0;
    drain(0);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (sb.expected_writes.size() != 0)
      $display("%0d dest writes never came out", sb.expected_writes.size());
    if (sb.mismatches == 0 && sb.expected_writes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
